[rtl/sbmp_pkg.sv]
package sbmp_pkg;

	localparam int MaxBands = 64;
	localparam int AmpBits = 16;
	localparam int FreqBits = 32;
	localparam int CfgBits = 21;
	localparam int CountBits = 7;
	localparam int IndexBits = 6;
	localparam int QDepth = 4;
	localparam int QPtrBits = 2;

	localparam logic [CfgBits-1:0] SpacingReset = 21'd2756;
	localparam logic [CfgBits-1:0] LowWidthReset = 21'd64000;
	localparam logic [CfgBits-1:0] HighWidthReset = 21'd64000;
	localparam logic [CountBits-1:0] BandCountReset = 7'd32;
	// band 0 of the reset configuration lies in the lower half
	localparam logic [FreqBits-1:0] EdgeReset = 32'd64000;

	localparam logic [1:0] CFG_BIN_SPACING = 2'd0;
	localparam logic [1:0] CFG_LOW_BAND_WIDTH = 2'd1;
	localparam logic [1:0] CFG_HIGH_BAND_WIDTH = 2'd2;
	localparam logic [1:0] CFG_BAND_COUNT = 2'd3;

	typedef struct packed {
		logic [AmpBits-1:0] amp;
		logic last;
		logic [FreqBits-1:0] freq;
	} item_t;

	typedef struct packed {
		logic [CfgBits-1:0] spacing;
		logic [CfgBits-1:0] low_width;
		logic [CfgBits-1:0] high_width;
		logic [CountBits-1:0] n;
	} cfg_t;

	typedef struct packed {
		logic flushing;
		logic emitting;
	} bk_stat_t;

	typedef enum logic {
		BK_RUN,
		BK_FLUSH
	} bk_state_t;

	function automatic logic [FreqBits-1:0] sat_add(input logic [FreqBits-1:0] a,
			input logic [CfgBits-1:0] b);
		logic [FreqBits:0] s;
		s = {1'b0, a} + {12'd0, b};
		return s[FreqBits] ? '1 : s[FreqBits-1:0];
	endfunction

endpackage

[rtl/sbmp_front.sv]
module sbmp_front import sbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [AmpBits-1:0] amplitude,
	input  logic last_bin,
	input  logic [CfgBits-1:0] spacing,
	input  logic q_full,
	output logic push,
	output item_t push_item
);

	logic [FreqBits-1:0] freq_q;

	assign item_ready = !q_full;
	assign push = item_valid && item_ready;

	always_comb begin
		push_item.amp = amplitude;
		push_item.last = last_bin;
		push_item.freq = freq_q;
	end

	// restart the bin frequency after the last bin of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (push) begin
			freq_q <= last_bin ? '0 : sat_add(freq_q, spacing);
		end
	end

endmodule

[rtl/sbmp_queue.sv]
module sbmp_queue import sbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  item_t push_item,
	output logic full,
	input  logic pop,
	output item_t head_item,
	output logic empty
);

	item_t entries_q [QDepth];
	logic [QPtrBits-1:0] wr_ptr_q;
	logic [QPtrBits-1:0] rd_ptr_q;
	logic [QPtrBits:0] count_q;

	assign full = count_q == (QPtrBits+1)'(QDepth);
	assign empty = count_q == '0;
	assign head_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/sbmp_back.sv]
module sbmp_back import sbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic reload,
	input  logic q_empty,
	input  item_t head_item,
	output logic pop,
	output bk_stat_t stat,
	output logic result_valid,
	input  logic result_ready,
	output logic [AmpBits-1:0] band_max,
	output logic [IndexBits-1:0] band_index,
	output logic last_band
);

	bk_state_t state_q, state_d;
	logic [FreqBits-1:0] edge_q, edge_d;
	logic [CountBits-1:0] band_q, band_d;
	logic [AmpBits-1:0] max_q, max_d;
	logic out_valid_q;

	logic hot;
	logic slot_free;
	logic emit;
	logic [CountBits-1:0] band_next;
	logic [CfgBits-1:0] width0;
	logic [CfgBits-1:0] width_next;

	assign hot = band_q < cfg.n;
	assign slot_free = !out_valid_q || result_ready;
	assign band_next = band_q + 1'b1;
	assign width0 = ((cfg.n >> 1) != '0) ? cfg.low_width : cfg.high_width;
	assign width_next = (band_next < (cfg.n >> 1)) ? cfg.low_width : cfg.high_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		edge_d = edge_q;
		band_d = band_q;
		max_d = max_q;
		emit = 1'b0;
		pop = 1'b0;
		unique case (state_q)
			BK_RUN: begin
				if (!q_empty) begin
					if (hot && head_item.freq >= edge_q) begin
						emit = slot_free;
					end else begin
						pop = 1'b1;
						if (hot && head_item.amp > max_q) begin
							max_d = head_item.amp;
						end
						if (head_item.last) begin
							state_d = BK_FLUSH;
						end
					end
				end else if (reload && band_q == '0) begin
					edge_d = {11'd0, width0};
				end
			end
			BK_FLUSH: begin
				if (hot) begin
					emit = slot_free;
				end else begin
					band_d = '0;
					max_d = '0;
					edge_d = {11'd0, width0};
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
		if (emit) begin
			max_d = '0;
			band_d = band_next;
			edge_d = sat_add(edge_q, width_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= EdgeReset;
			band_q <= '0;
			max_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			edge_q <= edge_d;
			band_q <= band_d;
			max_q <= max_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			band_max <= max_q;
			band_index <= band_q[IndexBits-1:0];
			last_band <= band_next == cfg.n;
		end
	end

	assign result_valid = out_valid_q;

	always_comb begin
		stat.flushing = state_q == BK_FLUSH;
		stat.emitting = emit;
	end

endmodule

[rtl/spectrum_band_max_pooler_core.sv]
// Spectrum band max pooler.
// Item channel (item_valid/item_ready, amplitude, last_bin) takes one spectrum
// bin per transfer, lowest frequency first, last_bin on the frame's final bin.
// Result channel (result_valid/result_ready, band_max, band_index, last_band)
// gives one transfer per closed band, last_band on the frame's final band.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// 0 bin spacing, 1 low band width, 2 high band width, 3 band count. Write it
// only while the block is idle.
// A bin enters a four-entry queue at its transfer; the first result it closes
// passes through the queue and then the result register. The band unit either
// retires a bin or closes a band, never both at once, and a last bin sends it
// into a flush that closes the remaining bands and restarts the frame.
// When a result waits and result_ready is low, the band unit holds before it
// closes another band; bins keep being taken until the queue is full, then item_ready drops.
// Reset loads the register defaults (2756, 64000, 64000, 32), empties the
// queue and starts a fresh frame at band 0.
module spectrum_band_max_pooler_core import sbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [AmpBits-1:0] amplitude,
	input  logic last_bin,
	output logic result_valid,
	input  logic result_ready,
	output logic [AmpBits-1:0] band_max,
	output logic [IndexBits-1:0] band_index,
	output logic last_band,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [CfgBits-1:0] cfg_data
);

	logic [CfgBits-1:0] spacing_q;
	logic [CfgBits-1:0] low_width_q;
	logic [CfgBits-1:0] high_width_q;
	logic [CountBits-1:0] band_count_q;
	logic reload_q;
	cfg_t cfg;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	item_t push_item;
	item_t head_item;
	bk_stat_t bk_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SpacingReset;
			low_width_q <= LowWidthReset;
			high_width_q <= HighWidthReset;
			band_count_q <= BandCountReset;
			reload_q <= 1'b0;
		end else begin
			reload_q <= cfg_valid && cfg_ready && (cfg_index != CFG_BIN_SPACING);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BIN_SPACING: spacing_q <= cfg_data;
					CFG_LOW_BAND_WIDTH: low_width_q <= cfg_data;
					CFG_HIGH_BAND_WIDTH: high_width_q <= cfg_data;
					CFG_BAND_COUNT: band_count_q <= cfg_data[CountBits-1:0];
					default: spacing_q <= spacing_q;
				endcase
			end
		end
	end

	always_comb begin
		cfg.spacing = spacing_q;
		cfg.low_width = low_width_q;
		cfg.high_width = high_width_q;
		cfg.n = (band_count_q > CountBits'(MaxBands)) ? CountBits'(MaxBands) : band_count_q;
	end

	sbmp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.amplitude(amplitude),
		.last_bin(last_bin),
		.spacing(cfg.spacing),
		.q_full(q_full),
		.push(q_push),
		.push_item(push_item)
	);

	sbmp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(push_item),
		.full(q_full),
		.pop(q_pop),
		.head_item(head_item),
		.empty(q_empty)
	);

	sbmp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.reload(reload_q),
		.q_empty(q_empty),
		.head_item(head_item),
		.pop(q_pop),
		.stat(bk_stat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.band_max(band_max),
		.band_index(band_index),
		.last_band(last_band)
	);

	a_last_band_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_band == (({1'b0, band_index} + 7'd1) == cfg.n)))
		else $error("last_band disagrees with active band count");

	a_no_pop_while_flushing: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.flushing |-> !q_pop)
		else $error("queue popped during flush");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("queue popped while empty");

	a_no_emit_and_pop: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.emitting |-> !q_pop)
		else $error("band closed and bin retired in one cycle");

endmodule

[sim/tb_spectrum_band_max_pooler_core.sv]
`timescale 1ns / 100ps

module tb_spectrum_band_max_pooler_core;
	import sbmp_pkg::*;

	localparam int RandomBins = 320;
	localparam int DrainCycles = 24;
	localparam int CalmStart = 4000;
	localparam int CalmEnd = 7000;
	localparam int SatBins = 40;

	typedef struct packed {
		logic [AmpBits-1:0] amp;
		logic closing;
	} bin_t;

	typedef struct packed {
		logic [AmpBits-1:0] peak;
		logic [IndexBits-1:0] index;
		logic is_last;
	} band_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [AmpBits-1:0] amplitude = '0;
	logic last_bin = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [AmpBits-1:0] band_max;
	logic [IndexBits-1:0] band_index;
	logic last_band;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_BIN_SPACING;
	logic [CfgBits-1:0] cfg_data = '0;

	spectrum_band_max_pooler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.amplitude(amplitude),
		.last_bin(last_bin),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.band_max(band_max),
		.band_index(band_index),
		.last_band(last_band),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// pooling model: registers and frame state
	logic [CfgBits-1:0] spacing_r, low_w_r, high_w_r;
	logic [CountBits-1:0] count_r;
	logic [FreqBits-1:0] freq_p, edge_p;
	logic [CountBits-1:0] band_p;
	logic [AmpBits-1:0] max_p;

	bin_t bin_q[$];
	band_rec_t expected_bands[$];
	bin_t next_bin;
	band_rec_t want_band;

	int cycle_cnt;
	int errors;
	int live_bins;
	int sent_bins;
	int frames;
	int bands_seen;
	int reg_writes;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("** spectrum_band_max_pooler_core: FAILED **");
		$finish;
	end

	function automatic logic idle_roll();
		return (cycle_cnt < CalmStart || cycle_cnt >= CalmEnd) && $urandom_range(99) < 9;
	endfunction

	function automatic logic [CountBits-1:0] bands_in_use();
		return (count_r > CountBits'(MaxBands)) ? CountBits'(MaxBands) : count_r;
	endfunction

	function automatic logic [CfgBits-1:0] width_for(input logic [CountBits-1:0] band,
			input logic [CountBits-1:0] n);
		return (band < (n >> 1)) ? low_w_r : high_w_r;
	endfunction

	function automatic logic [FreqBits-1:0] add_clamped(input logic [FreqBits-1:0] a,
			input logic [CfgBits-1:0] b);
		logic [FreqBits:0] s;
		s = {1'b0, a} + (FreqBits + 1)'(b);
		return s[FreqBits] ? '1 : s[FreqBits-1:0];
	endfunction

	task automatic restart_frame();
		freq_p = '0;
		band_p = '0;
		max_p = '0;
		edge_p = FreqBits'(width_for('0, bands_in_use()));
	endtask

	task automatic close_band(input logic [CountBits-1:0] n);
		band_rec_t rec;
		rec.peak = max_p;
		rec.index = band_p[IndexBits-1:0];
		rec.is_last = (band_p + 1'b1 == n);
		expected_bands.push_back(rec);
		max_p = '0;
		band_p = band_p + 1'b1;
		edge_p = add_clamped(edge_p, width_for(band_p, n));
	endtask

	task automatic predict_bin(input logic [AmpBits-1:0] amp, input logic closing);
		logic [CountBits-1:0] n;
		logic [FreqBits-1:0] f;
		n = bands_in_use();
		f = freq_p;
		if (band_p < n || closing)
			live_bins++;
		while (band_p < n && f >= edge_p)
			close_band(n);
		if (band_p < n && amp > max_p)
			max_p = amp;
		freq_p = add_clamped(f, spacing_r);
		if (closing) begin
			while (band_p < n)
				close_band(n);
			restart_frame();
			frames++;
		end
	endtask

	task automatic apply_reg(input logic [1:0] idx, input logic [CfgBits-1:0] data);
		case (idx)
			CFG_BIN_SPACING: spacing_r = data;
			CFG_LOW_BAND_WIDTH: low_w_r = data;
			CFG_HIGH_BAND_WIDTH: high_w_r = data;
			CFG_BAND_COUNT: count_r = data[CountBits-1:0];
		endcase
		// width or count written while still in band 0: reload the first edge
		if (idx != CFG_BIN_SPACING && band_p == '0)
			edge_p = FreqBits'(width_for('0, bands_in_use()));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CfgBits-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic push_bin(input logic [AmpBits-1:0] amp, input logic closing);
		bin_t b;
		b.amp = amp;
		b.closing = closing;
		bin_q.push_back(b);
		sent_bins++;
	endtask

	// hold until every bin is in and every band is out, then let the core drain
	task automatic settle();
		do @(posedge clk); while (bin_q.size() != 0 || item_valid || expected_bands.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [AmpBits-1:0] pick_amp();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return AmpBits'($urandom);
		endcase
	endfunction

	function automatic logic [CfgBits-1:0] pick_spacing();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return CfgBits'($urandom);
			default: return CfgBits'($urandom_range(1, 100000));
		endcase
	endfunction

	function automatic logic [CfgBits-1:0] pick_width(input logic [CfgBits-1:0] step);
		logic [31:0] w;
		logic [31:0] base;
		base = (step == '0) ? 32'd1000 : 32'(step);
		w = base * $urandom_range(4) + $urandom_range(base);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return CfgBits'($urandom);
			default: return (w > 32'h1FFFFF) ? '1 : w[CfgBits-1:0];
		endcase
	endfunction

	function automatic logic [CfgBits-1:0] pick_count();
		logic [CountBits-1:0] c;
		case ($urandom_range(9))
			0: c = CountBits'($urandom_range(1));
			1: c = CountBits'(MaxBands);
			2: c = CountBits'($urandom_range(MaxBands + 1, 127));
			default: c = CountBits'($urandom_range(2, 16));
		endcase
		return {(CfgBits - CountBits)'($urandom), c};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			amplitude <= '0;
			last_bin <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				predict_bin(amplitude, last_bin);
			if (!item_valid || item_ready) begin
				if (bin_q.size() != 0 && !idle_roll()) begin
					next_bin = bin_q.pop_front();
					item_valid <= 1'b1;
					amplitude <= next_bin.amp;
					last_bin <= next_bin.closing;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			cycle_cnt <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (result_valid && result_ready) begin
				bands_seen++;
				if (expected_bands.size() == 0) begin
					if (errors < 10)
						$display("unexpected band transfer: max %h index %0d last %0d",
							band_max, band_index, last_band);
					errors++;
				end else begin
					want_band = expected_bands.pop_front();
					if (band_max !== want_band.peak || band_index !== want_band.index ||
							last_band !== want_band.is_last) begin
						if (errors < 10)
							$display("band mismatch: expected max %h index %0d last %0d, got max %h index %0d last %0d",
								want_band.peak, want_band.index, want_band.is_last,
								band_max, band_index, last_band);
						errors++;
					end
				end
			end
			result_ready <= !idle_roll();
		end
	end

	initial begin
		int send_goal;
		int nframes;
		int len;
		logic open_end;
		logic noisy;
		logic [CfgBits-1:0] s;

		spacing_r = SpacingReset;
		low_w_r = LowWidthReset;
		high_w_r = HighWidthReset;
		count_r = BandCountReset;
		restart_frame();
		errors = 0;
		live_bins = 0;
		sent_bins = 0;
		frames = 0;
		bands_seen = 0;
		reg_writes = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: short frame, flush of all default bands
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'h0001, 1'b0);
		push_bin(16'h8000, 1'b0);
		push_bin(16'h5555, 1'b1);
		settle();

		// two unit bands, then bins past the last band are dropped
		write_reg(CFG_BIN_SPACING, 21'd1);
		write_reg(CFG_LOW_BAND_WIDTH, 21'd1);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'd1);
		write_reg(CFG_BAND_COUNT, 21'd2);
		push_bin(16'h1234, 1'b0);
		push_bin(16'hAAAA, 1'b0);
		push_bin(16'h00FF, 1'b0);
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'h0F0F, 1'b1);
		settle();

		// no bands at all
		write_reg(CFG_BAND_COUNT, 21'd0);
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'h7777, 1'b1);
		settle();

		// one band: band 0 takes the upper-half width
		write_reg(CFG_LOW_BAND_WIDTH, 21'd5);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'd3);
		write_reg(CFG_BAND_COUNT, 21'd1);
		push_bin(16'd7, 1'b0);
		push_bin(16'd9, 1'b0);
		push_bin(16'd3, 1'b0);
		push_bin(16'd2, 1'b0);
		push_bin(16'hC3C3, 1'b1);
		settle();

		// oversize count, widest spacing, empty upper bands: all bands in one bin
		write_reg(CFG_BIN_SPACING, 21'h1FFFFF);
		write_reg(CFG_LOW_BAND_WIDTH, 21'd1);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'd0);
		write_reg(CFG_BAND_COUNT, 21'h1FFF7F);
		push_bin(16'hFFFF, 1'b0);
		push_bin(16'h4321, 1'b0);
		push_bin(16'h0001, 1'b1);
		settle();

		// zero spacing: every bin at frequency zero
		write_reg(CFG_BIN_SPACING, 21'd0);
		write_reg(CFG_LOW_BAND_WIDTH, 21'h1FFFFF);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'h1FFFFF);
		write_reg(CFG_BAND_COUNT, 21'd4);
		push_bin(16'h0F0F, 1'b0);
		push_bin(16'hF0F0, 1'b0);
		push_bin(16'h1111, 1'b1);
		settle();

		// count lowered below the band in progress
		write_reg(CFG_BIN_SPACING, 21'd10);
		write_reg(CFG_LOW_BAND_WIDTH, 21'd10);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'd10);
		write_reg(CFG_BAND_COUNT, 21'd8);
		repeat (6) push_bin(pick_amp(), 1'b0);
		settle();
		write_reg(CFG_BAND_COUNT, 21'd4);
		push_bin(16'hBEEF, 1'b0);
		push_bin(16'h2222, 1'b1);
		settle();

		// run past every band, then raise the count so the next bin closes new bands
		write_reg(CFG_BIN_SPACING, 21'h1FFFFF);
		write_reg(CFG_LOW_BAND_WIDTH, 21'd1000);
		write_reg(CFG_HIGH_BAND_WIDTH, 21'd1000);
		write_reg(CFG_BAND_COUNT, 21'd2);
		repeat (SatBins) push_bin(pick_amp(), 1'b0);
		settle();
		write_reg(CFG_BAND_COUNT, 21'd6);
		push_bin(16'h9999, 1'b0);
		push_bin(16'h3333, 1'b1);
		settle();

		send_goal = sent_bins + RandomBins;
		while (sent_bins < send_goal) begin
			s = pick_spacing();
			if ($urandom_range(1))
				write_reg(CFG_BIN_SPACING, s);
			else
				s = spacing_r;
			if ($urandom_range(1))
				write_reg(CFG_LOW_BAND_WIDTH, pick_width(s));
			if ($urandom_range(1))
				write_reg(CFG_HIGH_BAND_WIDTH, pick_width(s));
			if ($urandom_range(1))
				write_reg(CFG_BAND_COUNT, pick_count());
			nframes = $urandom_range(1, 4);
			open_end = ($urandom_range(3) == 0);
			for (int fr = 0; fr < nframes; fr++) begin
				len = $urandom_range(1, 40);
				noisy = ($urandom_range(9) == 0);
				for (int i = 0; i < len; i++) begin
					if (noisy)
						push_bin(pick_amp(), $urandom_range(3) == 0);
					else
						push_bin(pick_amp(),
							i == len - 1 && !(open_end && fr == nframes - 1));
				end
			end
			settle();
		end

		$display("covered %0d live bins in %0d frames, %0d band transfers, %0d register writes",
			live_bins, frames, bands_seen, reg_writes);
		if (errors == 0)
			$display("** spectrum_band_max_pooler_core: PASSED **");
		else
			$display("** spectrum_band_max_pooler_core: FAILED **");
		$finish;
	end

endmodule
